// ===== hdl/ictf_pkg.sv =====
`timescale 1ns / 1ps

package ictf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;

    localparam int MUL_W  = 25;
    localparam int PROD_W = 50;
    localparam int RAD_W  = 48;
    localparam int ROOT_W = 24;
    localparam int XY_W   = 28;

    typedef enum logic [2:0] {
        REG_ACC_WEIGHT   = 3'd0,
        REG_GYRO_SCALE   = 3'd1,
        REG_GYRO_BIAS_X  = 3'd2,
        REG_GYRO_BIAS_Y  = 3'd3,
        REG_ACC_OFFSET_X = 3'd4,
        REG_ACC_OFFSET_Y = 3'd5,
        REG_ACC_OFFSET_Z = 3'd6
    } cfg_reg_t;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Accelerometer misalignment correction, Q2.14.
    function automatic logic signed [15:0] mat_coef(input logic [1:0] row,
                                                    input logic [1:0] col);
        logic signed [15:0] c;
        unique case ({row, col})
            4'b0000: c = -16'sd16579;
            4'b0001: c = 16'sd103;
            4'b0010: c = 16'sd62;
            4'b0100: c = 16'sd249;
            4'b0101: c = 16'sd16566;
            4'b0110: c = -16'sd59;
            4'b1000: c = -16'sd546;
            4'b1001: c = 16'sd709;
            4'b1010: c = 16'sd16051;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

    // Arctangent of 2^-i, rescaled from Q.30 to ab fractional bits.
    function automatic logic signed [63:0] atan_entry(input logic [4:0] i, input int ab);
        logic signed [63:0] q;
        logic signed [63:0] r;
        unique case (i)
            5'd0:  q = 64'sd843314857;
            5'd1:  q = 64'sd497837829;
            5'd2:  q = 64'sd263043837;
            5'd3:  q = 64'sd133525159;
            5'd4:  q = 64'sd67021687;
            5'd5:  q = 64'sd33543516;
            5'd6:  q = 64'sd16775851;
            5'd7:  q = 64'sd8388437;
            5'd8:  q = 64'sd4194283;
            5'd9:  q = 64'sd2097149;
            5'd10: q = 64'sd1048576;
            5'd11: q = 64'sd524288;
            5'd12: q = 64'sd262144;
            5'd13: q = 64'sd131072;
            5'd14: q = 64'sd65536;
            5'd15: q = 64'sd32768;
            5'd16: q = 64'sd16384;
            5'd17: q = 64'sd8192;
            5'd18: q = 64'sd4096;
            5'd19: q = 64'sd2048;
            5'd20: q = 64'sd1024;
            5'd21: q = 64'sd512;
            5'd22: q = 64'sd256;
            5'd23: q = 64'sd128;
            default: q = 64'sd0;
        endcase
        if (ab >= 30) begin
            r = q <<< (ab - 30);
        end else begin
            r = (q + (64'sd1 <<< (29 - ab))) >>> (30 - ab);
        end
        return r;
    endfunction

endpackage

// ===== hdl/ictf_isqrt.sv =====
`timescale 1ns / 1ps

module ictf_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ictf_pkg::RAD_W-1:0] n_in,
    output logic                       done,
    output logic [ictf_pkg::ROOT_W-1:0] root
);
    import ictf_pkg::*;

    logic [RAD_W-1:0] rem_reg;
    logic [RAD_W-1:0] res_reg;
    logic [RAD_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RAD_W:0]   trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= n_in;
                res_reg  <= '0;
                bit_reg  <= RAD_W'(1) << (RAD_W - 2);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_reg <= rem_reg - trial[RAD_W-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg == RAD_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== hdl/ictf_cordic.sv =====
`timescale 1ns / 1ps

module ictf_cordic #(
    parameter int STEPS      = ictf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS = ictf_pkg::ANGLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ictf_pkg::ROOT_W-1:0] x_in,
    input  logic signed [15:0]          a_in,
    output logic                        done,
    output logic signed [15:0]          angle
);
    import ictf_pkg::*;

    localparam int ZW = ANGLE_BITS + 3;
    localparam int IW = $clog2(STEPS);

    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [ZW-1:0]   z_reg;
    logic [IW-1:0]          i_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [63:0]     t_full;
    logic signed [ZW-1:0]   t;
    logic signed [63:0]     z_wide;
    logic signed [63:0]     z_scaled;

    assign dx     = y_reg >>> i_reg;
    assign dy     = x_reg >>> i_reg;
    assign t_full = atan_entry(5'(i_reg), ANGLE_BITS);
    assign t      = t_full[ZW-1:0];
    assign z_wide = 64'(z_reg);

    generate
        if (ANGLE_BITS > 13)
        begin : g_round
            assign z_scaled = (z_wide + (64'sd1 <<< (ANGLE_BITS - 14))) >>> (ANGLE_BITS - 13);
        end
        else
        begin : g_widen
            assign z_scaled = z_wide <<< (13 - ANGLE_BITS);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg <= signed'({{(XY_W-ROOT_W){1'b0}}, x_in});
                y_reg <= signed'({{(XY_W-24){a_in[15]}}, a_in, 8'h00});
                z_reg <= '0;
                i_reg <= '0;
                // A zero vector finishes at once with a zero angle.
                if (x_in == '0 && a_in == 16'sd0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (!y_reg[XY_W-1])
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + t;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - t;
                end
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign angle = sat16(z_scaled);

endmodule

// ===== hdl/imu_complementary_tilt_filter.sv =====
`timescale 1ns / 1ps

// Complementary tilt filter for roll and pitch.
// Input channel (in_valid/in_ready) takes one accelerometer triple and one gyro
// x/y pair per transfer; a fresh flag of 0 reuses the sample held from before.
// Output channel (out_valid/out_ready) returns one result per input transfer:
// fused, accelerometer-only and gyro-propagated angles plus calibrated accel.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while the filter is idle.
// One shared multiplier does the correction matrix, squares, gyro scaling and
// blending; an iterative square root and an iterative CORDIC unit follow it.
// Most of the time per item goes to the two square roots of 24 steps each
// and the two CORDIC runs. in_ready rises again once the result is registered,
// so a new item is taken only when the last one has left the sequencer.
// If the receiver stalls, the result waits in the output register
// while the next item is taken and computed; that item then holds until the
// output register is free. Reset restores the default configuration and clears
// the held samples and the previous fused angles.

module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ictf_pkg::ANGLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] acc_x,
    input  logic signed [15:0] acc_y,
    input  logic signed [15:0] acc_z,
    input  logic               acc_fresh,
    input  logic signed [23:0] gyro_x,
    input  logic signed [23:0] gyro_y,
    input  logic               gyro_fresh,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] fused_roll,
    output logic signed [15:0] fused_pitch,
    output logic signed [15:0] acc_roll,
    output logic signed [15:0] acc_pitch,
    output logic signed [15:0] gyro_roll,
    output logic signed [15:0] gyro_pitch,
    output logic signed [15:0] cal_acc_x,
    output logic signed [15:0] cal_acc_y,
    output logic signed [15:0] cal_acc_z
);
    import ictf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAT_MUL,
        S_MAT_ACC,
        S_SQ_B,
        S_SQ_C,
        S_SQ_SUM,
        S_SQRT,
        S_CORDIC,
        S_GYRO_MUL,
        S_GYRO_ADD,
        S_FUSE_A,
        S_FUSE_G,
        S_FUSE_SUM,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [15:0]        acc_weight_reg;
    logic [23:0]        gyro_scale_reg;
    logic signed [23:0] gyro_bias_x_reg;
    logic signed [23:0] gyro_bias_y_reg;
    logic signed [15:0] acc_offset_x_reg;
    logic signed [15:0] acc_offset_y_reg;
    logic signed [15:0] acc_offset_z_reg;

    logic signed [15:0] held_acc_x_reg;
    logic signed [15:0] held_acc_y_reg;
    logic signed [15:0] held_acc_z_reg;
    logic signed [23:0] held_gyro_x_reg;
    logic signed [23:0] held_gyro_y_reg;
    logic signed [15:0] prev_fused_roll_reg;
    logic signed [15:0] prev_fused_pitch_reg;

    logic [1:0]          row_reg;
    logic [1:0]          col_reg;
    logic                sel_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [15:0]  cal_reg [3];
    logic signed [15:0]  acc_ang_reg [2];
    logic signed [15:0]  gyro_ang_reg [2];
    logic signed [15:0]  fused_reg [2];

    logic                out_valid_reg;
    logic signed [15:0]  fused_roll_reg;
    logic signed [15:0]  fused_pitch_reg;
    logic signed [15:0]  acc_roll_reg;
    logic signed [15:0]  acc_pitch_reg;
    logic signed [15:0]  gyro_roll_reg;
    logic signed [15:0]  gyro_pitch_reg;
    logic signed [15:0]  cal_acc_x_reg;
    logic signed [15:0]  cal_acc_y_reg;
    logic signed [15:0]  cal_acc_z_reg;

    logic signed [16:0]       z_val [3];
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] acc_next;
    logic signed [PROD_W-1:0] mat_round;
    logic signed [24:0]       gyro_diff;
    logic signed [15:0]       prev_sel;
    logic signed [63:0]       gyro_sum;
    logic signed [PROD_W-1:0] fuse_round;
    logic [16:0]              w_comp;
    logic signed [15:0]       tilt_a;
    logic signed [15:0]       tilt_b;
    logic signed [15:0]       tilt_c;
    logic [RAD_W-1:0]         sq_n;
    logic                     sq_start;
    logic                     sq_done;
    logic [ROOT_W-1:0]        sq_root;
    logic                     cd_start;
    logic                     cd_done;
    logic signed [15:0]       cd_angle;
    logic                     in_xfer;
    logic                     out_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign z_val[0] = {held_acc_x_reg[15], held_acc_x_reg}
                    + {acc_offset_x_reg[15], acc_offset_x_reg};
    assign z_val[1] = {held_acc_y_reg[15], held_acc_y_reg}
                    + {acc_offset_y_reg[15], acc_offset_y_reg};
    assign z_val[2] = {held_acc_z_reg[15], held_acc_z_reg}
                    + {acc_offset_z_reg[15], acc_offset_z_reg};

    // Roll pass uses (cy, cx), pitch pass uses (cx, cy); cz is common.
    assign tilt_a = sel_reg ? cal_reg[0] : cal_reg[1];
    assign tilt_b = sel_reg ? cal_reg[1] : cal_reg[0];
    assign tilt_c = cal_reg[2];

    assign gyro_diff = sel_reg ?
        ({held_gyro_y_reg[23], held_gyro_y_reg} - {gyro_bias_y_reg[23], gyro_bias_y_reg}) :
        ({held_gyro_x_reg[23], held_gyro_x_reg} - {gyro_bias_x_reg[23], gyro_bias_x_reg});
    assign prev_sel = sel_reg ? prev_fused_pitch_reg : prev_fused_roll_reg;
    assign w_comp   = 17'h10000 - {1'b0, acc_weight_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MAT_MUL:
            begin
                mul_a = MUL_W'(z_val[col_reg]);
                mul_b = MUL_W'(mat_coef(row_reg, col_reg));
            end
            S_SQ_B:
            begin
                mul_a = MUL_W'(tilt_b);
                mul_b = MUL_W'(tilt_b);
            end
            S_SQ_C:
            begin
                mul_a = MUL_W'(tilt_c);
                mul_b = MUL_W'(tilt_c);
            end
            S_GYRO_MUL:
            begin
                mul_a = gyro_diff;
                mul_b = signed'({1'b0, gyro_scale_reg});
            end
            S_FUSE_A:
            begin
                mul_a = signed'({9'b0, acc_weight_reg});
                mul_b = MUL_W'(acc_ang_reg[sel_reg]);
            end
            S_FUSE_G:
            begin
                mul_a = signed'({8'b0, w_comp});
                mul_b = MUL_W'(gyro_ang_reg[sel_reg]);
            end
            default:
            begin
            end
        endcase
    end

    assign acc_next   = acc_reg + prod_reg;
    assign mat_round  = (acc_next + PROD_W'(8192)) >>> 14;
    assign gyro_sum   = 64'(prev_sel) + ((64'(prod_reg) + 64'sd1073741824) >>> 31);
    assign fuse_round = (acc_reg + prod_reg + PROD_W'(32768)) >>> 16;

    assign sq_n     = {acc_next[31:0], 16'h0000};
    assign sq_start = (state_reg == S_SQ_SUM);
    assign cd_start = (state_reg == S_SQRT) && sq_done;

    ictf_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .n_in  (sq_n),
        .done  (sq_done),
        .root  (sq_root)
    );

    ictf_cordic #(
        .STEPS      (CORDIC_STEPS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .x_in  (sq_root),
        .a_in  (tilt_a),
        .done  (cd_done),
        .angle (cd_angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_weight_reg   <= 16'd655;
            gyro_scale_reg   <= 24'd98642;
            gyro_bias_x_reg  <= 24'sd4550;
            gyro_bias_y_reg  <= 24'sd95;
            acc_offset_x_reg <= 16'sd435;
            acc_offset_y_reg <= -16'sd67;
            acc_offset_z_reg <= 16'sd351;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACC_WEIGHT:   acc_weight_reg   <= cfg_data[15:0];
                REG_GYRO_SCALE:   gyro_scale_reg   <= cfg_data;
                REG_GYRO_BIAS_X:  gyro_bias_x_reg  <= signed'(cfg_data);
                REG_GYRO_BIAS_Y:  gyro_bias_y_reg  <= signed'(cfg_data);
                REG_ACC_OFFSET_X: acc_offset_x_reg <= signed'(cfg_data[15:0]);
                REG_ACC_OFFSET_Y: acc_offset_y_reg <= signed'(cfg_data[15:0]);
                REG_ACC_OFFSET_Z: acc_offset_z_reg <= signed'(cfg_data[15:0]);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            held_acc_x_reg       <= '0;
            held_acc_y_reg       <= '0;
            held_acc_z_reg       <= '0;
            held_gyro_x_reg      <= '0;
            held_gyro_y_reg      <= '0;
            prev_fused_roll_reg  <= '0;
            prev_fused_pitch_reg <= '0;
            row_reg              <= '0;
            col_reg              <= '0;
            sel_reg              <= 1'b0;
            prod_reg             <= '0;
            acc_reg              <= '0;
            cal_reg              <= '{default: '0};
            acc_ang_reg          <= '{default: '0};
            gyro_ang_reg         <= '{default: '0};
            fused_reg            <= '{default: '0};
            out_valid_reg        <= 1'b0;
            fused_roll_reg       <= '0;
            fused_pitch_reg      <= '0;
            acc_roll_reg         <= '0;
            acc_pitch_reg        <= '0;
            gyro_roll_reg        <= '0;
            gyro_pitch_reg       <= '0;
            cal_acc_x_reg        <= '0;
            cal_acc_y_reg        <= '0;
            cal_acc_z_reg        <= '0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (acc_fresh)
                        begin
                            held_acc_x_reg <= acc_x;
                            held_acc_y_reg <= acc_y;
                            held_acc_z_reg <= acc_z;
                        end
                        if (gyro_fresh)
                        begin
                            held_gyro_x_reg <= gyro_x;
                            held_gyro_y_reg <= gyro_y;
                        end
                        row_reg   <= '0;
                        col_reg   <= '0;
                        sel_reg   <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= S_MAT_MUL;
                    end
                end
                S_MAT_MUL:
                begin
                    state_reg <= S_MAT_ACC;
                end
                S_MAT_ACC:
                begin
                    if (col_reg == 2'd2)
                    begin
                        cal_reg[row_reg] <= sat16(64'(mat_round));
                        acc_reg          <= '0;
                        col_reg          <= '0;
                        if (row_reg == 2'd2)
                        begin
                            state_reg <= S_SQ_B;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 2'd1;
                            state_reg <= S_MAT_MUL;
                        end
                    end
                    else
                    begin
                        acc_reg   <= acc_next;
                        col_reg   <= col_reg + 2'd1;
                        state_reg <= S_MAT_MUL;
                    end
                end
                S_SQ_B:
                begin
                    acc_reg   <= '0;
                    state_reg <= S_SQ_C;
                end
                S_SQ_C:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_SQ_SUM;
                end
                S_SQ_SUM:
                begin
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_done)
                    begin
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC:
                begin
                    if (cd_done)
                    begin
                        acc_ang_reg[sel_reg] <= cd_angle;
                        sel_reg              <= !sel_reg;
                        acc_reg              <= '0;
                        state_reg            <= sel_reg ? S_GYRO_MUL : S_SQ_B;
                    end
                end
                S_GYRO_MUL:
                begin
                    state_reg <= S_GYRO_ADD;
                end
                S_GYRO_ADD:
                begin
                    gyro_ang_reg[sel_reg] <= sat16(gyro_sum);
                    sel_reg               <= !sel_reg;
                    state_reg             <= sel_reg ? S_FUSE_A : S_GYRO_MUL;
                end
                S_FUSE_A:
                begin
                    state_reg <= S_FUSE_G;
                end
                S_FUSE_G:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_FUSE_SUM;
                end
                S_FUSE_SUM:
                begin
                    fused_reg[sel_reg] <= sat16(64'(fuse_round));
                    if (sel_reg)
                    begin
                        prev_fused_pitch_reg <= sat16(64'(fuse_round));
                        state_reg            <= S_DONE;
                    end
                    else
                    begin
                        prev_fused_roll_reg <= sat16(64'(fuse_round));
                        state_reg           <= S_FUSE_A;
                    end
                    sel_reg <= !sel_reg;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        fused_roll_reg  <= fused_reg[0];
                        fused_pitch_reg <= fused_reg[1];
                        acc_roll_reg    <= acc_ang_reg[0];
                        acc_pitch_reg   <= acc_ang_reg[1];
                        gyro_roll_reg   <= gyro_ang_reg[0];
                        gyro_pitch_reg  <= gyro_ang_reg[1];
                        cal_acc_x_reg   <= cal_reg[0];
                        cal_acc_y_reg   <= cal_reg[1];
                        cal_acc_z_reg   <= cal_reg[2];
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign fused_roll  = fused_roll_reg;
    assign fused_pitch = fused_pitch_reg;
    assign acc_roll    = acc_roll_reg;
    assign acc_pitch   = acc_pitch_reg;
    assign gyro_roll   = gyro_roll_reg;
    assign gyro_pitch  = gyro_pitch_reg;
    assign cal_acc_x   = cal_acc_x_reg;
    assign cal_acc_y   = cal_acc_y_reg;
    assign cal_acc_z   = cal_acc_z_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_MAT_MUL))
        else $error("Sequencer did not start after an input transfer.");

    a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_SQRT))
        else $error("Square root finished outside its wait state.");

    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        cd_done |-> (state_reg == S_CORDIC))
        else $error("CORDIC finished outside its wait state.");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("New result overwrote a result still waiting for transfer.");

endmodule

// ===== test/imu_complementary_tilt_filter_tb.sv =====
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_tb;
    import ictf_pkg::*;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               afresh;
        logic signed [23:0] gx;
        logic signed [23:0] gy;
        logic               gfresh;
    } imu_sample_t;

    typedef struct {
        logic signed [15:0] f_roll;
        logic signed [15:0] f_pitch;
        logic signed [15:0] a_roll;
        logic signed [15:0] a_pitch;
        logic signed [15:0] g_roll;
        logic signed [15:0] g_pitch;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } tilt_result_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic               acc_fresh;
    logic signed [23:0] gyro_x;
    logic signed [23:0] gyro_y;
    logic               gyro_fresh;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] fused_roll;
    logic signed [15:0] fused_pitch;
    logic signed [15:0] acc_roll;
    logic signed [15:0] acc_pitch;
    logic signed [15:0] gyro_roll;
    logic signed [15:0] gyro_pitch;
    logic signed [15:0] cal_acc_x;
    logic signed [15:0] cal_acc_y;
    logic signed [15:0] cal_acc_z;

    imu_complementary_tilt_filter dut (.*);

    // Predictor copy of configuration and state.
    logic [15:0]        m_weight;
    logic [23:0]        m_scale;
    logic signed [23:0] m_bias_x;
    logic signed [23:0] m_bias_y;
    logic signed [15:0] m_off_x;
    logic signed [15:0] m_off_y;
    logic signed [15:0] m_off_z;
    logic signed [15:0] h_ax;
    logic signed [15:0] h_ay;
    logic signed [15:0] h_az;
    logic signed [23:0] h_gx;
    logic signed [23:0] h_gy;
    logic signed [15:0] last_roll;
    logic signed [15:0] last_pitch;

    tilt_result_t pending_results[$];
    int  errors;
    int  items_sent;
    int  results_seen;
    int  cfg_writes;
    bit  idle_on;
    int  hold_request;
    int  quiet_cycles;

    longint atan_tab[24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [15:0] tilt_angle(longint a, longint b, longint c);
        longint unsigned n;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint t;
        n = longint'(b * b + c * c);
        n = n << 16;
        x = int_sqrt(n);
        y = a * 256;
        z = 0;
        if (x == 0 && y == 0)
            return 16'sd0;
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            t = (ANGLE_BITS_DEF >= 30) ? (atan_tab[i] <<< (ANGLE_BITS_DEF - 30))
                : round_shift(atan_tab[i], 30 - ANGLE_BITS_DEF);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + t;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - t;
            end
        end
        return clamp16(round_shift(z, ANGLE_BITS_DEF - 13));
    endfunction

    function automatic tilt_result_t predict_tilt(imu_sample_t s);
        tilt_result_t r;
        longint zx;
        longint zy;
        longint zz;
        longint w;
        if (s.afresh)
        begin
            h_ax = s.ax;
            h_ay = s.ay;
            h_az = s.az;
        end
        if (s.gfresh)
        begin
            h_gx = s.gx;
            h_gy = s.gy;
        end
        zx = longint'(h_ax) + longint'(m_off_x);
        zy = longint'(h_ay) + longint'(m_off_y);
        zz = longint'(h_az) + longint'(m_off_z);
        r.cx = clamp16(round_shift(-16579 * zx + 103 * zy + 62 * zz, 14));
        r.cy = clamp16(round_shift(249 * zx + 16566 * zy - 59 * zz, 14));
        r.cz = clamp16(round_shift(-546 * zx + 709 * zy + 16051 * zz, 14));
        r.a_pitch = tilt_angle(r.cx, r.cy, r.cz);
        r.a_roll = tilt_angle(r.cy, r.cx, r.cz);
        r.g_roll = clamp16(longint'(last_roll) + round_shift(
            (longint'(h_gx) - longint'(m_bias_x)) * longint'(m_scale), 31));
        r.g_pitch = clamp16(longint'(last_pitch) + round_shift(
            (longint'(h_gy) - longint'(m_bias_y)) * longint'(m_scale), 31));
        w = longint'(m_weight);
        r.f_roll = clamp16(round_shift(w * r.a_roll + (65536 - w) * r.g_roll, 16));
        r.f_pitch = clamp16(round_shift(w * r.a_pitch + (65536 - w) * r.g_pitch, 16));
        last_roll = r.f_roll;
        last_pitch = r.f_pitch;
        return r;
    endfunction

    task automatic compare_field(string name, logic signed [15:0] e, logic signed [15:0] a);
        if (e !== a)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, e, a);
            errors++;
        end
    endtask

    // Result checker and output-side stall generator.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        tilt_result_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no expected result pending");
                    errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    compare_field("fused_roll", e.f_roll, fused_roll);
                    compare_field("fused_pitch", e.f_pitch, fused_pitch);
                    compare_field("acc_roll", e.a_roll, acc_roll);
                    compare_field("acc_pitch", e.a_pitch, acc_pitch);
                    compare_field("gyro_roll", e.g_roll, gyro_roll);
                    compare_field("gyro_pitch", e.g_pitch, gyro_pitch);
                    compare_field("cal_acc_x", e.cx, cal_acc_x);
                    compare_field("cal_acc_y", e.cy, cal_acc_y);
                    compare_field("cal_acc_z", e.cz, cal_acc_z);
                end
            end
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_sample(imu_sample_t s);
        acc_x <= s.ax;
        acc_y <= s.ay;
        acc_z <= s.az;
        acc_fresh <= s.afresh;
        gyro_x <= s.gx;
        gyro_y <= s.gy;
        gyro_fresh <= s.gfresh;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_tilt(s));
        items_sent++;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ACC_WEIGHT:   m_weight = value[15:0];
            REG_GYRO_SCALE:   m_scale = value;
            REG_GYRO_BIAS_X:  m_bias_x = value;
            REG_GYRO_BIAS_Y:  m_bias_y = value;
            REG_ACC_OFFSET_X: m_off_x = value[15:0];
            REG_ACC_OFFSET_Y: m_off_y = value[15:0];
            REG_ACC_OFFSET_Z: m_off_z = value[15:0];
            default: ;
        endcase
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic imu_sample_t make_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                                logic signed [15:0] az, logic af,
                                                logic signed [23:0] gx, logic signed [23:0] gy,
                                                logic gf);
        imu_sample_t s;
        s.ax = ax;
        s.ay = ay;
        s.az = az;
        s.afresh = af;
        s.gx = gx;
        s.gy = gy;
        s.gfresh = gf;
        return s;
    endfunction

    function automatic imu_sample_t random_sample();
        imu_sample_t s;
        if ($urandom_range(0, 9) < 7)
        begin
            s.ax = 16'($signed($urandom_range(0, 12000)) - 6000);
            s.ay = 16'($signed($urandom_range(0, 12000)) - 6000);
            s.az = 16'($signed($urandom_range(0, 12000)) - 6000);
        end
        else
        begin
            s.ax = 16'($urandom);
            s.ay = 16'($urandom);
            s.az = 16'($urandom);
        end
        if ($urandom_range(0, 9) < 7)
        begin
            s.gx = 24'($signed($urandom_range(0, 2000000)) - 1000000);
            s.gy = 24'($signed($urandom_range(0, 2000000)) - 1000000);
        end
        else
        begin
            s.gx = 24'($urandom);
            s.gy = 24'($urandom);
        end
        s.afresh = ($urandom_range(0, 3) != 0);
        s.gfresh = ($urandom_range(0, 3) != 0);
        return s;
    endfunction

    task automatic random_config();
        write_reg(REG_ACC_WEIGHT, 24'($urandom_range(0, 65535)));
        write_reg(REG_GYRO_SCALE, 24'($urandom_range(0, 24'hffffff)));
        write_reg(REG_GYRO_BIAS_X, 24'($urandom));
        write_reg(REG_GYRO_BIAS_Y, 24'($urandom));
        write_reg(REG_ACC_OFFSET_X, 24'($urandom_range(0, 65535)));
        write_reg(REG_ACC_OFFSET_Y, 24'($urandom_range(0, 65535)));
        write_reg(REG_ACC_OFFSET_Z, 24'($urandom_range(0, 65535)));
    endtask

    task automatic test_stale_after_reset();
        send_sample(make_sample(16'sd1000, 16'sd2000, 16'sd3000, 1'b0, 24'sd5000, 24'sd6000, 1'b0));
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd4096, 1'b1, 24'sd0, 24'sd0, 1'b0));
        drain_results();
    endtask

    task automatic test_directed_extremes();
        write_reg(REG_ACC_OFFSET_X, 24'd0);
        write_reg(REG_ACC_OFFSET_Y, 24'd0);
        write_reg(REG_ACC_OFFSET_Z, 24'd0);
        write_reg(REG_GYRO_BIAS_X, 24'd0);
        write_reg(REG_GYRO_BIAS_Y, 24'd0);
        // A zero accel vector gives a zero tilt angle.
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, 24'sd0, 24'sd0, 1'b1));
        send_sample(make_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1,
                                24'sh7fffff, 24'sh7fffff, 1'b1));
        send_sample(make_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
                                24'sh800000, 24'sh800000, 1'b1));
        send_sample(make_sample(16'sh7fff, 16'sh8000, 16'sd0, 1'b1, 24'sh7fffff, 24'sh800000, 1'b1));
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd0, 1'b0, 24'sd0, 24'sd0, 1'b0));
        send_sample(make_sample(16'sd4096, 16'sd0, 16'sd0, 1'b1, 24'sd0, 24'sd0, 1'b0));
        send_sample(make_sample(16'sd0, -16'sd4096, 16'sd0, 1'b1, 24'sd4096, -24'sd4096, 1'b1));
        drain_results();
        write_reg(REG_GYRO_SCALE, 24'hffffff);
        write_reg(REG_ACC_WEIGHT, 24'd0);
        write_reg(REG_GYRO_BIAS_X, 24'h800000);
        write_reg(REG_GYRO_BIAS_Y, 24'h7fffff);
        write_reg(REG_ACC_OFFSET_X, 24'h007fff);
        write_reg(REG_ACC_OFFSET_Y, 24'h008000);
        write_reg(REG_ACC_OFFSET_Z, 24'h007fff);
        // Full scale gyro rates drive the propagated angles into saturation.
        for (int i = 0; i < 4; i++)
            send_sample(make_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1,
                                    24'sh7fffff, 24'sh800000, 1'b1));
        send_sample(make_sample(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1,
                                24'sh800000, 24'sh7fffff, 1'b1));
        drain_results();
        write_reg(REG_ACC_WEIGHT, 24'hffff);
        write_reg(REG_GYRO_SCALE, 24'd0);
        write_reg(REG_ACC_OFFSET_X, 24'h008000);
        write_reg(REG_ACC_OFFSET_Y, 24'h007fff);
        write_reg(REG_ACC_OFFSET_Z, 24'h008000);
        for (int i = 0; i < 4; i++)
            send_sample(random_sample());
        drain_results();
    endtask

    task automatic test_random_configs(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            random_config();
            if (p % 4 == 0)
                write_reg(REG_ACC_WEIGHT, (p % 8 == 0) ? 24'd0 : 24'hffff);
            for (int i = 0; i < per_phase; i++)
                send_sample(random_sample());
            drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        hold_request = 3000;
        for (int i = 0; i < 20; i++)
            send_sample(random_sample());
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ACC_WEIGHT;
        cfg_data = '0;
        in_valid = 1'b0;
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        acc_fresh = 1'b0;
        gyro_x = '0;
        gyro_y = '0;
        gyro_fresh = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        cfg_writes = 0;
        idle_on = 1'b1;
        hold_request = 0;
        quiet_cycles = 0;
        m_weight = 16'd655;
        m_scale = 24'd98642;
        m_bias_x = 24'sd4550;
        m_bias_y = 24'sd95;
        m_off_x = 16'sd435;
        m_off_y = -16'sd67;
        m_off_z = 16'sd351;
        h_ax = '0;
        h_ay = '0;
        h_az = '0;
        h_gx = '0;
        h_gy = '0;
        last_roll = '0;
        last_pitch = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stale_after_reset();
        test_directed_extremes();
        test_random_configs(10, 100);
        test_output_backpressure();
        test_random_configs(10, 50);
        idle_on = 1'b0;
        test_random_configs(4, 50);

        drain_results();
        repeat (300) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        $display("Run covered %0d samples, %0d results and %0d register writes,",
                 items_sent, results_seen, cfg_writes);
        $display("with stale samples, saturation, idling on both sides and a long output stall.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
